FILE: design/hwl_pkg.sv
`timescale 1ns / 1ps
package hwl_pkg;
   localparam int COLUMNS_DEF = 16;
   localparam logic [31:0] LIMIT_RESET = 32'd999999999;
   localparam logic [7:0] BAR_HEIGHT_RESET = 8'd127;
   localparam logic [7:0] CENTER_Y_RESET = 8'd32;
   localparam logic [7:0] BALL_SIZE_RESET = 8'd3;
   localparam logic [4:0] COLS_IN_USE_RESET = 5'd16;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_CLEAR  = 2'd1,
      KIND_READ   = 2'd2,
      KIND_RENDER = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_LIMIT_TOTAL  = 3'd0,
      REG_LIMIT_COLUMN = 3'd1,
      REG_BAR_HEIGHT   = 3'd2,
      REG_CENTER_Y     = 3'd3,
      REG_BALL_SIZE    = 3'd4,
      REG_COLS_IN_USE  = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MUL,
      ST_DIV,
      ST_SEND
   } state_type;
endpackage

FILE: design/histogram_with_limits_and_bar_scaling_unit.sv
`timescale 1ns / 1ps
// channel | direction | tdata (low bit up)                          | tuser | tlast
// req     | in        | column[7:0]                                  | kind  | -
// rsp     | out       | column_index, column_count, total_count,     | -     | last
//         |           | limit_reached, bar_length, row_top,          |       |
//         |           | row_bottom, draw_bar, 6 pad zeros (104 bits)  |       |
// add and read: the request passes the fetch and send states and the result is registered;
//    the next request is accepted back in idle once the result register is empty
// clear: handled in idle, no result; render gives none with no counts or no columns
// render, per column: 32-step shift-add multiply of count by bar height
//    (last 8 steps add), then a 40-step restoring divide by the largest count,
//    one bit per cycle in one shared shift-register datapath, then the send state
// reset clears all counts, total, largest and the registers to their defaults
// one request at a time; a held result blocks the next column and new requests
module histogram_with_limits_and_bar_scaling_unit #(
   parameter int COLUMNS = hwl_pkg::COLUMNS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // column
   input  logic [1:0]   req_tuser,   // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // see table above
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   localparam int IW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

   // configuration
   logic [31:0] lim_tot_ff, lim_col_ff;
   logic [7:0]  bar_h_ff, cen_y_ff, ball_ff;
   logic [4:0]  ciu_ff;

   // state
   logic [31:0] counts_ff [COLUMNS];
   logic [31:0] total_ff, largest_ff;

   hwl_pkg::state_type state_ff, state_in;
   hwl_pkg::kind_type  kind_ff;
   logic [7:0]  col_ff;
   logic [IW-1:0] idx_ff;
   logic [5:0]  step_ff;
   logic [39:0] prod_ff;     // multiply product, then divide quotient/dividend
   logic [31:0] mcand_ff;
   logic [7:0]  mplier_ff;
   logic [32:0] rem_ff;
   logic [7:0]  y_ff;
   logic [4:0]  walk_ff;

   // result register
   logic        ov_ff, ov_in;
   logic [7:0]  o_idx_ff, o_bar_ff, o_top_ff, o_bot_ff;
   logic [31:0] o_cnt_ff, o_tot_ff;
   logic        o_lim_ff, o_draw_ff, o_last_ff;

   logic        in_range;
   logic [31:0] cur_cnt;
   logic [31:0] inc_cnt, inc_tot;
   logic [8:0]  pitch;
   logic [12:0] span;
   logic [4:0]  walk_n;
   logic [32:0] rem_sh;
   logic        req_go;

   assign req_tready = (state_ff == hwl_pkg::ST_IDLE) && !ov_ff;
   assign req_go = req_tvalid && req_tready;
   assign in_range = {24'd0, col_ff} < 32'(COLUMNS);
   assign cur_cnt = in_range ? counts_ff[col_ff[IW-1:0]] : 32'd0;
   assign inc_cnt = cur_cnt + 32'd1;
   assign inc_tot = total_ff + 32'd1;
   assign pitch = {1'b0, ball_ff} + 9'd1;
   assign span = {4'd0, pitch} * {8'd0, ciu_ff}; // narrow 9x5 multiply
   assign walk_n = ({27'd0, ciu_ff} < 32'(COLUMNS)) ? ciu_ff : 5'(COLUMNS);
   assign rem_sh = {rem_ff[31:0], prod_ff[39]};

   assign rsp_tvalid = ov_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {6'd0, o_draw_ff, o_bot_ff, o_top_ff, o_bar_ff,
                        o_lim_ff, o_tot_ff, o_cnt_ff, o_idx_ff};

   // result register: loads in send, empties when taken
   always_comb begin
      ov_in = ov_ff && !rsp_tready;
      if (state_ff == hwl_pkg::ST_SEND && (!ov_ff || rsp_tready)) ov_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_tot_ff <= hwl_pkg::LIMIT_RESET;
         lim_col_ff <= hwl_pkg::LIMIT_RESET;
         bar_h_ff <= hwl_pkg::BAR_HEIGHT_RESET;
         cen_y_ff <= hwl_pkg::CENTER_Y_RESET;
         ball_ff <= hwl_pkg::BALL_SIZE_RESET;
         ciu_ff <= hwl_pkg::COLS_IN_USE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            hwl_pkg::REG_LIMIT_TOTAL:  lim_tot_ff <= csr_data;
            hwl_pkg::REG_LIMIT_COLUMN: lim_col_ff <= csr_data;
            hwl_pkg::REG_BAR_HEIGHT:   bar_h_ff <= csr_data[7:0];
            hwl_pkg::REG_CENTER_Y:     cen_y_ff <= csr_data[7:0];
            hwl_pkg::REG_BALL_SIZE:    ball_ff <= csr_data[7:0];
            hwl_pkg::REG_COLS_IN_USE:  ciu_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= hwl_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hwl_pkg::ST_IDLE: begin
            if (req_go) begin
               if (hwl_pkg::kind_type'(req_tuser) == hwl_pkg::KIND_CLEAR)
                  state_in = hwl_pkg::ST_IDLE;
               else if (hwl_pkg::kind_type'(req_tuser) == hwl_pkg::KIND_RENDER)
                  state_in = (largest_ff == 32'd0 || walk_n == 5'd0) ?
                             hwl_pkg::ST_IDLE : hwl_pkg::ST_MUL;
               else state_in = hwl_pkg::ST_FETCH;
            end
         end
         hwl_pkg::ST_FETCH: state_in = hwl_pkg::ST_SEND;
         hwl_pkg::ST_MUL:   if (step_ff == 6'd31) state_in = hwl_pkg::ST_DIV;
         hwl_pkg::ST_DIV:   if (step_ff == 6'd39) state_in = hwl_pkg::ST_SEND;
         hwl_pkg::ST_SEND: begin
            if (!ov_ff || rsp_tready) begin
               if (kind_ff == hwl_pkg::KIND_RENDER &&
                   {{(8-IW){1'b0}}, idx_ff} + 8'd1 != {3'd0, walk_ff})
                  state_in = hwl_pkg::ST_MUL;
               else state_in = hwl_pkg::ST_IDLE;
            end
         end
         default: state_in = hwl_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COLUMNS; i++) counts_ff[i] <= 32'd0;
         total_ff <= 32'd0;
         largest_ff <= 32'd0;
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
         case (state_ff)
            hwl_pkg::ST_IDLE: begin
               if (req_go) begin
                  kind_ff <= hwl_pkg::kind_type'(req_tuser);
                  col_ff <= req_tdata;
                  idx_ff <= '0;
                  step_ff <= 6'd0;
                  walk_ff <= walk_n;
                  y_ff <= cen_y_ff - span[8:1];
                  prod_ff <= 40'd0;
                  mcand_ff <= counts_ff[0];
                  mplier_ff <= bar_h_ff;
                  if (hwl_pkg::kind_type'(req_tuser) == hwl_pkg::KIND_CLEAR) begin
                     for (int i = 0; i < COLUMNS; i++) counts_ff[i] <= 32'd0;
                     total_ff <= 32'd0;
                     largest_ff <= 32'd0;
                  end
               end
            end
            hwl_pkg::ST_FETCH: begin
               o_idx_ff <= col_ff;
               o_bar_ff <= 8'd0; o_top_ff <= 8'd0; o_bot_ff <= 8'd0;
               o_draw_ff <= 1'b0; o_last_ff <= 1'b1;
               if (kind_ff == hwl_pkg::KIND_ADD && in_range) begin
                  counts_ff[col_ff[IW-1:0]] <= inc_cnt;
                  total_ff <= inc_tot;
                  if (largest_ff < inc_cnt) largest_ff <= inc_cnt;
                  o_cnt_ff <= inc_cnt;
                  o_tot_ff <= inc_tot;
                  o_lim_ff <= (inc_tot >= lim_tot_ff) || (inc_cnt >= lim_col_ff);
               end else begin
                  o_cnt_ff <= cur_cnt;
                  o_tot_ff <= total_ff;
                  o_lim_ff <= (kind_ff == hwl_pkg::KIND_ADD);
               end
            end
            hwl_pkg::ST_MUL: begin
               // shift-add, msb first: one multiplier bit per cycle in the last 8 steps
               prod_ff <= {prod_ff[38:0], 1'b0} +
                          ((step_ff >= 6'd24 && mplier_ff[7]) ?
                           {8'd0, mcand_ff} : 40'd0);
               if (step_ff >= 6'd24) mplier_ff <= {mplier_ff[6:0], 1'b0};
               step_ff <= (step_ff == 6'd31) ? 6'd0 : step_ff + 6'd1;
               rem_ff <= 33'd0;
            end
            hwl_pkg::ST_DIV: begin
               // restoring divide, one quotient bit per cycle
               if (rem_sh >= {1'b0, largest_ff}) begin
                  rem_ff <= rem_sh - {1'b0, largest_ff};
                  prod_ff <= {prod_ff[38:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  prod_ff <= {prod_ff[38:0], 1'b0};
               end
               step_ff <= (step_ff == 6'd39) ? 6'd0 : step_ff + 6'd1;
            end
            hwl_pkg::ST_SEND: begin
               if (!ov_ff || rsp_tready) begin
                  if (kind_ff == hwl_pkg::KIND_RENDER) begin
                     o_idx_ff <= 8'(idx_ff);
                     o_cnt_ff <= mcand_ff;
                     o_tot_ff <= total_ff;
                     o_lim_ff <= 1'b0;
                     o_draw_ff <= mcand_ff != 32'd0;
                     o_bar_ff <= (mcand_ff != 32'd0) ? prod_ff[7:0] : 8'd0;
                     o_top_ff <= y_ff + 8'd1;
                     o_bot_ff <= y_ff + ball_ff;
                     o_last_ff <= {{(8-IW){1'b0}}, idx_ff} + 8'd1 == {3'd0, walk_ff};
                     y_ff <= y_ff + pitch[7:0];
                     idx_ff <= idx_ff + IW'(1);
                     mcand_ff <= counts_ff[IW'(idx_ff + IW'(1))];
                     mplier_ff <= bar_h_ff;
                     prod_ff <= 40'd0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == hwl_pkg::ST_IDLE)
      else $error("ready outside idle");
   a_largest: assert property (@(posedge clock) disable iff (reset)
      total_ff == 32'd0 && $past(total_ff) != 32'd0 |-> largest_ff == 32'd0)
      else $error("largest not cleared");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
`endif
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
   localparam int NCOL = hwl_pkg::COLUMNS_DEF;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int SETTLE = 120;

   // one expected response beat
   typedef struct packed {
      logic [7:0]  col;
      logic [31:0] cnt;
      logic [31:0] tot;
      logic        lim;
      logic [7:0]  bar;
      logic [7:0]  top;
      logic [7:0]  bot;
      logic        draw;
      logic        last;
   } hist_beat_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;   // column
   logic [1:0]   req_tuser = '0;   // kind
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;       // column_index, column_count, total_count, limit_reached,
                                  // bar_length, row_top, row_bottom, draw_bar, pad
   logic         rsp_tlast;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   histogram_with_limits_and_bar_scaling_unit #(.COLUMNS(NCOL)) dut (.*);

   always #2 clock = ~clock;

   // shadow copy of the histogram and its registers
   logic [31:0] sh_counts [NCOL];
   logic [31:0] sh_total, sh_largest;
   logic [31:0] sh_lim_total, sh_lim_col;
   logic [7:0]  sh_bar_h, sh_center, sh_ball;
   logic [4:0]  sh_cols;

   hist_beat_type pending_beats[$];
   int mismatches = 0;
   int beats_seen = 0;
   int requests_sent = 0;
   int renders_sent = 0;
   int send_idle = 0;      // percent of cycles the sender idles
   int recv_idle = 0;      // percent of cycles the receiver stalls
   int hold_cycles = 0;    // long receiver hold-off, counted down below
   int cycle_count = 0;

   function automatic hist_beat_type make_beat(logic [7:0] col, logic [31:0] cnt,
         logic lim, logic [7:0] bar, logic [7:0] top, logic [7:0] bot,
         logic draw, logic last);
      hist_beat_type b;
      b.col = col; b.cnt = cnt; b.tot = sh_total; b.lim = lim; b.bar = bar;
      b.top = top; b.bot = bot; b.draw = draw; b.last = last;
      return b;
   endfunction

   // advance the shadow histogram by one request and queue what it produces
   task automatic predict_histogram(hwl_pkg::kind_type k, logic [7:0] col);
      logic [31:0] c, walk, pitch, y, bar;
      logic [63:0] prod;
      case (k)
         hwl_pkg::KIND_ADD: begin
            if (col >= NCOL) begin
               pending_beats.push_back(make_beat(col, 0, 1'b1, 0, 0, 0, 1'b0, 1'b1));
            end else begin
               sh_total = sh_total + 1;
               sh_counts[col] = sh_counts[col] + 1;
               c = sh_counts[col];
               if (sh_largest < c) sh_largest = c;
               pending_beats.push_back(make_beat(col, c,
                  (sh_total >= sh_lim_total) || (c >= sh_lim_col), 0, 0, 0, 1'b0, 1'b1));
            end
         end
         hwl_pkg::KIND_CLEAR: begin
            foreach (sh_counts[i]) sh_counts[i] = '0;
            sh_total = '0;
            sh_largest = '0;
         end
         hwl_pkg::KIND_READ: begin
            c = (col < NCOL) ? sh_counts[col] : '0;
            pending_beats.push_back(make_beat(col, c, 1'b0, 0, 0, 0, 1'b0, 1'b1));
         end
         default: begin
            walk = (sh_cols < NCOL) ? sh_cols : NCOL;
            if (sh_largest != 0 && walk != 0) begin
               pitch = sh_ball + 1;
               y = (sh_center - ((pitch * sh_cols) >> 1)) & 32'hFF;
               for (int i = 0; i < walk; i++) begin
                  c = sh_counts[i];
                  bar = '0;
                  if (c != 0) begin
                     prod = {32'd0, c} * {56'd0, sh_bar_h};
                     bar = 32'(prod / {32'd0, sh_largest});
                  end
                  pending_beats.push_back(make_beat(i[7:0], c, 1'b0, bar[7:0],
                     y[7:0] + 8'd1, y[7:0] + sh_ball, c != 0, i + 1 == walk));
                  y = (y + pitch) & 32'hFF;
               end
            end
         end
      endcase
   endtask

   // offer one request; valid stays high into the next one unless the sender idles
   task automatic send_request(hwl_pkg::kind_type k, logic [7:0] col);
      req_tvalid <= 1'b1;
      req_tuser <= k;
      req_tdata <= col;
      do @(posedge clock); while (!req_tready);
      predict_histogram(k, col);
      requests_sent++;
      if (k == hwl_pkg::KIND_RENDER) renders_sent++;
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
   endtask

   // drop valid and let the block run empty, including work with no response
   task automatic drain_histogram();
      req_tvalid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(hwl_pkg::reg_index_type idx, logic [31:0] val);
      drain_histogram();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         hwl_pkg::REG_LIMIT_TOTAL:  sh_lim_total = val;
         hwl_pkg::REG_LIMIT_COLUMN: sh_lim_col = val;
         hwl_pkg::REG_BAR_HEIGHT:   sh_bar_h = val[7:0];
         hwl_pkg::REG_CENTER_Y:     sh_center = val[7:0];
         hwl_pkg::REG_BALL_SIZE:    sh_ball = val[7:0];
         hwl_pkg::REG_COLS_IN_USE:  sh_cols = val[4:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // receiver: random stalls, or a long hold-off when one is armed
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // response checker
   always @(posedge clock) begin
      hist_beat_type e, a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a.col  = rsp_tdata[7:0];
         a.cnt  = rsp_tdata[39:8];
         a.tot  = rsp_tdata[71:40];
         a.lim  = rsp_tdata[72];
         a.bar  = rsp_tdata[80:73];
         a.top  = rsp_tdata[88:81];
         a.bot  = rsp_tdata[96:89];
         a.draw = rsp_tdata[97];
         a.last = rsp_tlast;
         beats_seen++;
         if (pending_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: col %0d cnt %0d tot %0d", a.col, a.cnt, a.tot);
         end else begin
            e = pending_beats.pop_front();
            if (a !== e) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch exp: col %0d cnt %0d tot %0d lim %0b bar %0d top %0d bot %0d draw %0b last %0b",
                     e.col, e.cnt, e.tot, e.lim, e.bar, e.top, e.bot, e.draw, e.last);
                  $display("         got: col %0d cnt %0d tot %0d lim %0b bar %0d top %0d bot %0d draw %0b last %0b",
                     a.col, a.cnt, a.tot, a.lim, a.bar, a.top, a.bot, a.draw, a.last);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", pending_beats.size());
         $display("Verification failed");
         $finish;
      end
   end

   // extremes of both fields, every kind, render with empty store and out of range columns
   task automatic test_directed();
      send_request(hwl_pkg::KIND_RENDER, 8'd0);      // nothing counted yet: no bars
      send_request(hwl_pkg::KIND_READ, 8'd0);
      send_request(hwl_pkg::KIND_ADD, 8'd0);
      send_request(hwl_pkg::KIND_ADD, 8'd15);
      send_request(hwl_pkg::KIND_ADD, 8'd15);
      send_request(hwl_pkg::KIND_ADD, 8'd16);        // just past the store
      send_request(hwl_pkg::KIND_ADD, 8'd255);
      send_request(hwl_pkg::KIND_READ, 8'd15);
      send_request(hwl_pkg::KIND_READ, 8'd255);
      send_request(hwl_pkg::KIND_ADD, 8'hAA);
      send_request(hwl_pkg::KIND_ADD, 8'd5);
      send_request(hwl_pkg::KIND_RENDER, 8'hFF);     // column ignored
      send_request(hwl_pkg::KIND_CLEAR, 8'd3);
      send_request(hwl_pkg::KIND_READ, 8'd15);
      send_request(hwl_pkg::KIND_RENDER, 8'd0);      // cleared again: no bars
      send_request(hwl_pkg::KIND_ADD, 8'd7);
      send_request(hwl_pkg::KIND_RENDER, 8'd0);
   endtask

   // both limits at their extremes and at small reachable values
   task automatic test_limits();
      write_reg(hwl_pkg::REG_LIMIT_TOTAL, 32'd0);
      write_reg(hwl_pkg::REG_LIMIT_COLUMN, 32'hFFFF_FFFF);
      send_request(hwl_pkg::KIND_ADD, 8'd1);
      write_reg(hwl_pkg::REG_LIMIT_TOTAL, 32'hFFFF_FFFF);
      write_reg(hwl_pkg::REG_LIMIT_COLUMN, 32'd0);
      send_request(hwl_pkg::KIND_ADD, 8'd2);
      write_reg(hwl_pkg::REG_LIMIT_COLUMN, 32'd3);
      write_reg(hwl_pkg::REG_LIMIT_TOTAL, 32'd6);
      for (int i = 0; i < 6; i++) send_request(hwl_pkg::KIND_ADD, 8'(i % 3));
      write_reg(hwl_pkg::REG_LIMIT_TOTAL, hwl_pkg::LIMIT_RESET);
      write_reg(hwl_pkg::REG_LIMIT_COLUMN, hwl_pkg::LIMIT_RESET);
   endtask

   // render geometry across register extremes, odd sizes and column counts
   task automatic render_with(logic [7:0] bh, logic [7:0] cy, logic [7:0] bs, logic [4:0] cu);
      write_reg(hwl_pkg::REG_BAR_HEIGHT, bh);
      write_reg(hwl_pkg::REG_CENTER_Y, cy);
      write_reg(hwl_pkg::REG_BALL_SIZE, bs);
      write_reg(hwl_pkg::REG_COLS_IN_USE, cu);
      send_request(hwl_pkg::KIND_ADD, 8'($urandom_range(NCOL - 1)));
      send_request(hwl_pkg::KIND_RENDER, 8'd0);
   endtask

   task automatic test_render_settings();
      render_with(8'd255, 8'd0, 8'd1, 5'd1);
      render_with(8'd0, 8'd255, 8'd255, 5'd16);
      render_with(8'd200, 8'd10, 8'd4, 5'd31);   // walk stops at the store, centering does not
      render_with(8'd77, 8'd128, 8'd0, 5'd0);    // no columns to walk
      render_with(8'd255, 8'd250, 8'd7, 5'd9);
      render_with(hwl_pkg::BAR_HEIGHT_RESET, hwl_pkg::CENTER_Y_RESET,
                  hwl_pkg::BALL_SIZE_RESET, 5'd3);
   endtask

   // mostly adds on live columns, some reads and renders, rare clears and strays
   task automatic test_random(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 60)
            send_request(hwl_pkg::KIND_ADD, ($urandom_range(9) == 0) ? 8'($urandom) :
                                                              8'($urandom_range(NCOL - 1)));
         else if (r < 80)
            send_request(hwl_pkg::KIND_READ, ($urandom_range(5) == 0) ? 8'($urandom) :
                                                               8'($urandom_range(NCOL - 1)));
         else if (r < 93)
            send_request(hwl_pkg::KIND_RENDER, 8'($urandom));
         else
            send_request(hwl_pkg::KIND_CLEAR, 8'($urandom));
      end
   endtask

   // long receiver hold-off while requests keep coming, then a pause until drained
   task automatic test_backpressure();
      hold_cycles <= 600;
      for (int i = 0; i < 10; i++)
         send_request(hwl_pkg::KIND_ADD, 8'($urandom_range(NCOL - 1)));
      send_request(hwl_pkg::KIND_RENDER, 8'd0);
      req_tvalid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      send_request(hwl_pkg::KIND_READ, 8'd0);
   endtask

   initial begin
      sh_lim_total = hwl_pkg::LIMIT_RESET;
      sh_lim_col = hwl_pkg::LIMIT_RESET;
      sh_bar_h = hwl_pkg::BAR_HEIGHT_RESET;
      sh_center = hwl_pkg::CENTER_Y_RESET;
      sh_ball = hwl_pkg::BALL_SIZE_RESET;
      sh_cols = hwl_pkg::COLS_IN_USE_RESET;
      foreach (sh_counts[i]) sh_counts[i] = '0;
      sh_total = '0;
      sh_largest = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle = 6; recv_idle = 60;
      test_directed();
      test_limits();
      test_render_settings();
      write_reg(hwl_pkg::REG_COLS_IN_USE, 5'd6);
      test_random(60);
      test_backpressure();

      send_idle = 60; recv_idle = 6;
      write_reg(hwl_pkg::REG_BALL_SIZE, 8'd5);
      write_reg(hwl_pkg::REG_COLS_IN_USE, 5'd16);
      test_random(60);

      send_idle = 0; recv_idle = 0;
      write_reg(hwl_pkg::REG_BAR_HEIGHT, 8'd255);
      write_reg(hwl_pkg::REG_COLS_IN_USE, 5'd4);
      test_random(60);

      drain_histogram();
      $display("ran %0d requests (%0d renders), checked %0d responses, %0d mismatches",
         requests_sent, renders_sent, beats_seen, mismatches);
      $display("covered limits, render geometry extremes, idle mixes and a long stall");
      if (mismatches == 0 && pending_beats.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
